### design/bffa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants, codes and helpers for the first-fit bitmap allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int unsigned ENTRIES   = 131072;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned WORDS     = ENTRIES / WORD_BITS;
  localparam int unsigned WORD_AW   = $clog2(WORDS);
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned CNT_W     = WORD_AW + 1;
  localparam int unsigned CFG_W     = 18;
  localparam int unsigned IDX_W     = 17;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [CFG_W-1:0] TOTAL_RESET    = CFG_W'(ENTRIES);
  localparam logic [CFG_W-1:0] RESERVED_RESET = CFG_W'(2056);

  localparam logic REG_TOTAL    = 1'b0;
  localparam logic REG_RESERVED = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_FORMAT = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  function automatic word_t low_mask(logic [BIT_W-1:0] n);
    return (word_t'(1) << n) - word_t'(1);
  endfunction

endpackage
`default_nettype wire

### design/bitmap_first_fit_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_unit
// Used/free bitmap over 131072 entries held in a 2048 x 64 synchronous RAM.
// ----------------------------------------------------------------------------
// After reset the unit writes the reset bitmap to all 2048 words (the
// lowest 2056 entries used) and takes no transaction meanwhile. One request
// is handled at a time, one RAM word per cycle: an allocate reads words from
// the bottom until it finds a free entry or reaches total (capped at
// 131072); a free reads the word, writes it back and gives its result; a
// free out of range and an unused request code go straight to the result; a
// format sweeps all 2048 words. The final step of each request is held for
// as long as an earlier result still waits to be taken. The result register
// frees the input side while a finished result waits to be taken.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_unit (
  input  wire                                logic clk_i,
  input  wire                                logic rst_ni,
  input  wire                                logic in_valid_i,
  output                                     logic in_ready_o,
  input  wire logic [1:0]                    req_type_i,
  input  wire logic [bffa_pkg::IDX_W-1:0]    free_index_i,
  output                                     logic out_valid_o,
  input  wire                                logic out_ready_i,
  output logic [bffa_pkg::IDX_W-1:0]         alloc_index_o,
  output logic [1:0]                         status_o,
  input  wire                                logic psel,
  input  wire                                logic penable,
  input  wire                                logic pwrite,
  input  wire logic [bffa_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bffa_pkg::PDATA_W-1:0]  pwdata,
  output logic [bffa_pkg::PDATA_W-1:0]       prdata,
  output                                     logic pready
);
  import bffa_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_FMT,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [CFG_W-1:0]     total_q, total_d;
  logic [CFG_W-1:0]     reserved_q, reserved_d;
  logic [CFG_W-1:0]     lim_q, lim_d;
  logic [CFG_W-1:0]     n_q, n_d;
  logic [IDX_W-1:0]     fidx_q, fidx_d;
  logic [CNT_W-1:0]     rw_q, rw_d;
  logic [CNT_W-1:0]     sc_q, sc_d;
  logic [WORD_AW-1:0]   swc_q, swc_d;
  logic [IDX_W-1:0]     res_idx_q, res_idx_d;
  status_e              res_st_q, res_st_d;
  logic                 out_valid_q, out_valid_d;
  logic [IDX_W-1:0]     alloc_index_q, alloc_index_d;
  status_e              status_q, status_d;

  word_t                mem_q [WORDS];
  word_t                rd_data_q;
  logic                 mem_re, mem_we;
  logic [WORD_AW-1:0]   mem_ra, mem_wa;
  word_t                mem_wd;

  logic                 accept;
  logic                 cfg_we;
  logic [CFG_W-1:0]     lim;
  logic [CFG_W-1:0]     res_n;
  logic                 scan_end;
  word_t                scan_mask;
  word_t                avail;
  logic [BIT_W-1:0]     enc;
  word_t                pattern;

  assign in_ready_o    = (state_q == S_IDLE);
  assign accept        = in_valid_i & in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign alloc_index_o = alloc_index_q;
  assign status_o      = status_q;
  assign pready        = 1'b1;
  assign cfg_we        = psel & penable & pwrite;
  assign prdata        = (paddr[2] == REG_RESERVED) ? PDATA_W'(reserved_q)
                                                    : PDATA_W'(total_q);

  always_comb begin
    lim   = (total_q > CFG_W'(ENTRIES)) ? CFG_W'(ENTRIES) : total_q;
    res_n = (reserved_q > CFG_W'(ENTRIES)) ? CFG_W'(ENTRIES) : reserved_q;

    scan_end  = ({rw_q, BIT_W'(0)} >= lim_q);
    scan_mask = (lim_q[CFG_W-1:BIT_W] == rw_q) ? low_mask(lim_q[BIT_W-1:0]) : '1;
    avail     = ~rd_data_q & scan_mask;
    enc       = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        enc = BIT_W'(b);
      end
    end

    if (n_q[CFG_W-1:BIT_W] > {1'b0, swc_q}) begin
      pattern = '1;
    end else if (n_q[CFG_W-1:BIT_W] == {1'b0, swc_q}) begin
      pattern = low_mask(n_q[BIT_W-1:0]);
    end else begin
      pattern = '0;
    end
  end

  always_comb begin
    state_d       = state_q;
    total_d       = total_q;
    reserved_d    = reserved_q;
    lim_d         = lim_q;
    n_d           = n_q;
    fidx_d        = fidx_q;
    rw_d          = rw_q;
    sc_d          = sc_q;
    swc_d         = swc_q;
    res_idx_d     = res_idx_q;
    res_st_d      = res_st_q;
    out_valid_d   = out_valid_q;
    alloc_index_d = alloc_index_q;
    status_d      = status_q;
    mem_re        = 1'b0;
    mem_ra        = sc_q[WORD_AW-1:0];
    mem_we        = 1'b0;
    mem_wa        = swc_q;
    mem_wd        = pattern;

    if (cfg_we) begin
      if (paddr[2] == REG_RESERVED) begin
        reserved_d = pwdata[CFG_W-1:0];
      end else begin
        total_d = pwdata[CFG_W-1:0];
      end
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT, S_FMT: begin
        mem_we = 1'b1;
        swc_d  = swc_q + WORD_AW'(1);
        if (swc_q == WORD_AW'(WORDS - 1)) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_idx_d = '0;
          res_st_d  = ST_OK;
          case (req_e'(req_type_i))
            REQ_ALLOC: begin
              lim_d   = lim;
              mem_re  = 1'b1;
              mem_ra  = '0;
              sc_d    = CNT_W'(1);
              rw_d    = '0;
              state_d = S_SCAN;
            end
            REQ_FREE: begin
              if ({1'b0, free_index_i} >= lim) begin
                res_st_d = ST_RANGE;
                state_d  = S_DONE;
              end else begin
                fidx_d  = free_index_i;
                mem_re  = 1'b1;
                mem_ra  = free_index_i[IDX_W-1:BIT_W];
                state_d = S_FREE;
              end
            end
            REQ_FORMAT: begin
              n_d     = res_n;
              swc_d   = '0;
              state_d = S_FMT;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        mem_re = 1'b1;
        mem_ra = sc_q[WORD_AW-1:0];
        sc_d   = sc_q + CNT_W'(1);
        if (scan_end) begin
          res_st_d = ST_FULL;
          state_d  = S_DONE;
        end else if (avail != '0) begin
          mem_we    = 1'b1;
          mem_wa    = rw_q[WORD_AW-1:0];
          mem_wd    = rd_data_q | (word_t'(1) << enc);
          res_idx_d = IDX_W'({rw_q[WORD_AW-1:0], enc});
          state_d   = S_DONE;
        end else begin
          rw_d = rw_q + CNT_W'(1);
        end
      end
      S_FREE: begin
        mem_we  = 1'b1;
        mem_wa  = fidx_q[IDX_W-1:BIT_W];
        mem_wd  = rd_data_q & ~(word_t'(1) << fidx_q[BIT_W-1:0]);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          alloc_index_d = res_idx_q;
          status_d      = res_st_q;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_INIT;
      total_q       <= TOTAL_RESET;
      reserved_q    <= RESERVED_RESET;
      lim_q         <= '0;
      n_q           <= RESERVED_RESET;
      fidx_q        <= '0;
      rw_q          <= '0;
      sc_q          <= '0;
      swc_q         <= '0;
      res_idx_q     <= '0;
      res_st_q      <= ST_OK;
      out_valid_q   <= 1'b0;
      alloc_index_q <= '0;
      status_q      <= ST_OK;
    end else begin
      state_q       <= state_d;
      total_q       <= total_d;
      reserved_q    <= reserved_d;
      lim_q         <= lim_d;
      n_q           <= n_d;
      fidx_q        <= fidx_d;
      rw_q          <= rw_d;
      sc_q          <= sc_d;
      swc_q         <= swc_d;
      res_idx_q     <= res_idx_d;
      res_st_q      <= res_st_d;
      out_valid_q   <= out_valid_d;
      alloc_index_q <= alloc_index_d;
      status_q      <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem_q[mem_ra];
    end
  end

endmodule
`default_nettype wire
